FILE: rtl/core/mm3_pkg.sv
`timescale 1ns / 1ps
// shared widths and mixing constants for the 32-bit murmur3 hash core
// no dependencies

package mm3_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned CountW = 3;

  localparam logic [DataW-1:0]  MixC1    = 32'hcc9e2d51;
  localparam logic [DataW-1:0]  MixC2    = 32'h1b873593;
  localparam logic [DataW-1:0]  MixN     = 32'he6546b64;
  localparam logic [DataW-1:0]  MixTimes = 32'd5;
  localparam logic [DataW-1:0]  FinF1    = 32'h85ebca6b;
  localparam logic [DataW-1:0]  FinF2    = 32'hc2b2ae35;
  localparam logic [CountW-1:0] FullCnt  = 3'd4;

  function automatic logic [DataW-1:0] rotl15(input logic [DataW-1:0] v);
    rotl15 = {v[DataW-16:0], v[DataW-1:DataW-15]};
  endfunction

  function automatic logic [DataW-1:0] rotl13(input logic [DataW-1:0] v);
    rotl13 = {v[DataW-14:0], v[DataW-1:DataW-13]};
  endfunction

endpackage

FILE: rtl/core/mm3_ifs.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for key words in and hash words out
// depends on mm3_pkg for field widths

interface mm3_key_if;
  logic                       valid;
  logic                       ready;
  logic [mm3_pkg::DataW-1:0]  data_word;
  logic [mm3_pkg::CountW-1:0] byte_count;
  logic                       last;

  modport source (output valid, output data_word, output byte_count, output last,
                  input ready);
  modport sink   (input valid, input data_word, input byte_count, input last,
                  output ready);
endinterface

interface mm3_hash_if;
  logic                      valid;
  logic                      ready;
  logic [mm3_pkg::DataW-1:0] hash_value;

  modport source (output valid, output hash_value, input ready);
  modport sink   (input valid, input hash_value, output ready);
endinterface

FILE: rtl/core/murmur3_32_hash_core.sv
`timescale 1ns / 1ps
// murmur3 x86 32-bit hash over a stream of little-endian key words
// depends on mm3_pkg and the channel interfaces in mm3_ifs
//
// One key word is taken at a time. A full word that does not end the key takes
// the accept step and three passes through the single shared 32x32 multiplier
// (times c1, times c2, accumulator times 5). A full or short word that ends the
// key adds two passes for the finaliser multiplies; a zero-byte end word makes
// only the two finaliser passes. The hash sits in an output register, so the
// next key may start while it waits to be taken; a finished hash only holds the
// finaliser when the previous hash has still not been taken. The seed is sampled
// at the first word of each key.

module murmur3_32_hash_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [mm3_pkg::DataW-1:0] cfg_wdata_i,
  mm3_key_if.sink                   key_i,
  mm3_hash_if.source                hash_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMul1 = 3'd1;
  localparam logic [2:0] StMul2 = 3'd2;
  localparam logic [2:0] StMul3 = 3'd3;
  localparam logic [2:0] StFin1 = 3'd4;
  localparam logic [2:0] StFin2 = 3'd5;

  logic [2:0]                 state_q, state_d;
  logic                       in_key_q, in_key_d;
  logic                       last_q, last_d;
  logic                       full_q, full_d;
  logic                       out_valid_q, out_valid_d;
  logic [mm3_pkg::DataW-1:0]  seed_q;
  logic [mm3_pkg::DataW-1:0]  acc_q, acc_d;
  logic [mm3_pkg::DataW-1:0]  len_q, len_d;
  logic [mm3_pkg::DataW-1:0]  k_q, k_d;
  logic [mm3_pkg::DataW-1:0]  word_q, word_d;
  logic [mm3_pkg::DataW-1:0]  hash_q, hash_d;

  logic                       key_acc;
  logic                       fin_done;
  logic [mm3_pkg::CountW-1:0] cnt;
  logic [mm3_pkg::DataW-1:0]  word_masked;
  logic [mm3_pkg::DataW-1:0]  mul_a, mul_b, mul_p;
  logic [mm3_pkg::DataW-1:0]  fin_x, fin_t, mix_x;

  assign key_i.ready       = (state_q == StIdle);
  assign key_acc           = key_i.valid && key_i.ready;
  assign hash_o.valid      = out_valid_q;
  assign hash_o.hash_value = hash_q;
  assign fin_done          = (state_q == StFin2) && (!out_valid_q || hash_o.ready);

  // byte count above four counts as four
  assign cnt = (key_i.byte_count > mm3_pkg::FullCnt) ? mm3_pkg::FullCnt : key_i.byte_count;

  always_comb begin
    case (cnt)
      3'd1:    word_masked = {24'd0, key_i.data_word[7:0]};
      3'd2:    word_masked = {16'd0, key_i.data_word[15:0]};
      3'd3:    word_masked = {8'd0, key_i.data_word[23:0]};
      default: word_masked = key_i.data_word;
    endcase
  end

  assign fin_x = (acc_q ^ len_q) ^ ((acc_q ^ len_q) >> 16);
  assign fin_t = k_q ^ (k_q >> 13);
  assign mix_x = mm3_pkg::rotl13(acc_q ^ k_q);

  // shared multiplier, low word of the product
  always_comb begin
    unique case (state_q)
      StMul1: begin
        mul_a = word_q;
        mul_b = mm3_pkg::MixC1;
      end
      StMul2: begin
        mul_a = mm3_pkg::rotl15(k_q);
        mul_b = mm3_pkg::MixC2;
      end
      StMul3: begin
        mul_a = mix_x;
        mul_b = mm3_pkg::MixTimes;
      end
      StFin1: begin
        mul_a = fin_x;
        mul_b = mm3_pkg::FinF1;
      end
      StFin2: begin
        mul_a = fin_t;
        mul_b = mm3_pkg::FinF2;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    state_d     = state_q;
    in_key_d    = in_key_q;
    last_d      = last_q;
    full_d      = full_q;
    out_valid_d = out_valid_q;
    acc_d       = acc_q;
    len_d       = len_q;
    k_d         = k_q;
    word_d      = word_q;
    hash_d      = hash_q;

    if (out_valid_q && hash_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (key_acc) begin
          in_key_d = 1'b1;
          acc_d    = in_key_q ? acc_q : seed_q;
          len_d    = (in_key_q ? len_q : '0) + {{(mm3_pkg::DataW-mm3_pkg::CountW){1'b0}}, cnt};
          word_d   = word_masked;
          full_d   = (cnt == mm3_pkg::FullCnt);
          last_d   = key_i.last || (cnt != mm3_pkg::FullCnt);
          state_d  = (cnt == '0) ? StFin1 : StMul1;
        end
      end
      StMul1: begin
        k_d     = mul_p;
        state_d = StMul2;
      end
      StMul2: begin
        k_d     = mul_p;
        state_d = StMul3;
      end
      StMul3: begin
        // short tail skips the accumulator rotate and update
        acc_d   = full_q ? (mul_p + mm3_pkg::MixN) : (acc_q ^ k_q);
        state_d = last_q ? StFin1 : StIdle;
      end
      StFin1: begin
        k_d     = mul_p;
        state_d = StFin2;
      end
      StFin2: begin
        if (fin_done) begin
          hash_d      = mul_p ^ (mul_p >> 16);
          out_valid_d = 1'b1;
          in_key_d    = 1'b0;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      in_key_q    <= 1'b0;
      last_q      <= 1'b0;
      full_q      <= 1'b0;
      out_valid_q <= 1'b0;
      seed_q      <= '0;
    end else begin
      state_q     <= state_d;
      in_key_q    <= in_key_d;
      last_q      <= last_d;
      full_q      <= full_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        seed_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    len_q  <= len_d;
    k_q    <= k_d;
    word_q <= word_d;
    hash_q <= hash_d;
  end

  a_empty_word_to_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_acc && (key_i.byte_count == '0) |=> state_q == StFin1)
    else $error("zero-byte word did not go straight to the finaliser");

  a_full_word_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_acc && (cnt == mm3_pkg::FullCnt) && !key_i.last
      |=> state_q == StMul1 ##1 state_q == StMul2 ##1 state_q == StMul3 ##1 state_q == StIdle)
    else $error("full word did not take three multiplier passes");

  a_hash_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == StFin2)
    else $error("hash word raised outside the finaliser");

  a_key_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_done |=> !in_key_q && state_q == StIdle && out_valid_q)
    else $error("key not closed after hash word");

endmodule
